### design/rrgs_pkg.sv
// shared types and thresholds for the range gate selector
`default_nettype none

package rrgs_pkg;

    // gate code on the result item
    localparam logic [1:0] CODE_LOW   = 2'd0;
    localparam logic [1:0] CODE_INTER = 2'd1;
    localparam logic [1:0] CODE_HIGH  = 2'd2;

    // resolution state, one-hot
    typedef enum logic [2:0] {
        GATE_LOW   = 3'b001,
        GATE_INTER = 3'b010,
        GATE_HIGH  = 3'b100
    } gate_state_t;

    // configuration register indexes
    localparam logic [1:0] REG_OBJECT_MODE     = 2'd0;
    localparam logic [1:0] REG_USE_CTRL_STATUS = 2'd1;
    localparam logic [1:0] REG_DELAY_MS        = 2'd2;
    localparam logic [1:0] REG_CYCLE_MS        = 2'd3;

    localparam int unsigned PADDR_W = 4;
    localparam int unsigned PDATA_W = 32;

    // field widths
    localparam int unsigned SPEED_W = 14;
    localparam int unsigned DIST_W  = 13;
    localparam int unsigned MS_W    = 16;
    localparam int unsigned CYC_W   = 8;

    // speed thresholds, 1/32 km/h
    localparam logic signed [SPEED_W-1:0] V_REL_MAX     = 14'sd1152; // 36 km/h
    localparam logic signed [SPEED_W-1:0] V_GATE_DOWN   = 14'sd1216; // 40 - 2 km/h
    localparam logic signed [SPEED_W-1:0] V_GATE_UP     = 14'sd1344; // 40 + 2 km/h
    localparam logic signed [SPEED_W-1:0] V_CREEP_DOWN  = 14'sd96;   // 4 - 1 km/h
    localparam logic signed [SPEED_W-1:0] V_CREEP_UP    = 14'sd160;  // 4 + 1 km/h
    localparam logic signed [SPEED_W-1:0] V_FOLLOW      = 14'sd320;  // 10 km/h
    localparam logic signed [SPEED_W-1:0] V_SO_FINE     = 14'sd320;  // 10 km/h
    localparam logic signed [SPEED_W-1:0] V_SO_COARSE   = 14'sd480;  // 15 km/h

    // distance thresholds, 1/16 m
    localparam logic signed [DIST_W-1:0] D_NEAR_HIGH_IN  = 13'sd96;  // 8 - 2 m
    localparam logic signed [DIST_W-1:0] D_NEAR_LOW_IN   = 13'sd184; // 13.5 - 2 m
    localparam logic signed [DIST_W-1:0] D_NEAR_HIGH_OUT = 13'sd160; // 8 + 2 m
    localparam logic signed [DIST_W-1:0] D_NEAR_LOW_OUT  = 13'sd248; // 13.5 + 2 m
    localparam logic signed [DIST_W-1:0] D_TAIL_HIGH_IN  = 13'sd48;  // 4 - 1 m
    localparam logic signed [DIST_W-1:0] D_TAIL_LOW_IN   = 13'sd160; // 11 - 1 m
    localparam logic signed [DIST_W-1:0] D_TAIL_HIGH_OUT = 13'sd80;  // 4 + 1 m
    localparam logic signed [DIST_W-1:0] D_TAIL_LOW_OUT  = 13'sd192; // 11 + 1 m

    // reset values of the configuration registers
    localparam logic             RST_OBJECT_MODE     = 1'b1;
    localparam logic             RST_USE_CTRL_STATUS = 1'b1;
    localparam logic [MS_W-1:0]  RST_DELAY_MS        = 16'd0;
    localparam logic [CYC_W-1:0] RST_CYCLE_MS        = 8'd60;

endpackage

`default_nettype wire

### design/rrgs_if.sv
// item channels of the range gate selector
`default_nettype none

interface rrgs_in_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  speed_valid;
    logic signed [rrgs_pkg::SPEED_W-1:0]   ego_speed;
    logic                                  obj_present;
    logic signed [rrgs_pkg::SPEED_W-1:0]   obj_rel_speed;
    logic signed [rrgs_pkg::DIST_W-1:0]    obj_distance;
    logic                                  roadbeam_request;
    logic                                  forced_high_res;
    logic                                  standstill;
    logic                                  ctrl_enabled;

    modport source (
        output valid, speed_valid, ego_speed, obj_present, obj_rel_speed, obj_distance,
               roadbeam_request, forced_high_res, standstill, ctrl_enabled,
        input  ready
    );
    modport sink (
        input  valid, speed_valid, ego_speed, obj_present, obj_rel_speed, obj_distance,
               roadbeam_request, forced_high_res, standstill, ctrl_enabled,
        output ready
    );
endinterface

interface rrgs_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] gate_code;
    logic       power_reduction;

    modport source (
        output valid, gate_code, power_reduction,
        input  ready
    );
    modport sink (
        input  valid, gate_code, power_reduction,
        output ready
    );
endinterface

`default_nettype wire

### design/radar_range_gate_selector.sv
// range gate resolution selector with standstill power-reduction flag
// the result of an accepted input item is registered in the output register
// throughput: one item per clock while results are taken; the input is ready whenever
//   the output register is empty or being taken in the same cycle, so that register is the only stage
// reset (rst_n low, asynchronous): resolution state goes to 1 m, standstill counter to 0,
//   output register empties, configuration takes its reset values
`default_nettype none

module radar_range_gate_selector (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    rrgs_in_if.sink                                din,
    rrgs_out_if.source                             dout,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [rrgs_pkg::PADDR_W-1:0]      paddr,
    input  wire logic [rrgs_pkg::PDATA_W-1:0]      pwdata,
    output logic      [rrgs_pkg::PDATA_W-1:0]      prdata,
    output logic                                   pready
);

    // configuration registers
    logic                            object_mode_reg;
    logic                            use_ctrl_status_reg;
    logic [rrgs_pkg::MS_W-1:0]       delay_ms_reg;
    logic [rrgs_pkg::CYC_W-1:0]      cycle_ms_reg;

    // block state
    rrgs_pkg::gate_state_t           gate_state_reg, gate_state_next;
    logic [rrgs_pkg::MS_W-1:0]       standstill_ms_reg, standstill_ms_next;

    // output register
    logic                            out_valid_reg;
    logic [1:0]                      gate_code_reg, gate_code_next;
    logic                            power_reduction_reg, power_reduction_next;

    logic                            cfg_write;
    logic [1:0]                      cfg_index;
    logic                            in_fire;
    logic                            obj_eff;
    logic                            rel_fast;
    logic [1:0]                      rule_code;
    rrgs_pkg::gate_state_t           rule_state;
    logic                            pr_wanted;
    logic [rrgs_pkg::MS_W:0]         ms_sum;

    // ---------------------------------------------------------------
    // apb configuration port, writes take effect on the access cycle
    // ---------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            object_mode_reg     <= rrgs_pkg::RST_OBJECT_MODE;
            use_ctrl_status_reg <= rrgs_pkg::RST_USE_CTRL_STATUS;
            delay_ms_reg        <= rrgs_pkg::RST_DELAY_MS;
            cycle_ms_reg        <= rrgs_pkg::RST_CYCLE_MS;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                rrgs_pkg::REG_OBJECT_MODE:     object_mode_reg     <= pwdata[0];
                rrgs_pkg::REG_USE_CTRL_STATUS: use_ctrl_status_reg <= pwdata[0];
                rrgs_pkg::REG_DELAY_MS:        delay_ms_reg        <= pwdata[15:0];
                rrgs_pkg::REG_CYCLE_MS:        cycle_ms_reg        <= pwdata[7:0];
                default:                       ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_index)
            rrgs_pkg::REG_OBJECT_MODE:
                prdata = {{(rrgs_pkg::PDATA_W-1){1'b0}}, object_mode_reg};
            rrgs_pkg::REG_USE_CTRL_STATUS:
                prdata = {{(rrgs_pkg::PDATA_W-1){1'b0}}, use_ctrl_status_reg};
            rrgs_pkg::REG_DELAY_MS:
                prdata = {{(rrgs_pkg::PDATA_W-rrgs_pkg::MS_W){1'b0}}, delay_ms_reg};
            rrgs_pkg::REG_CYCLE_MS:
                prdata = {{(rrgs_pkg::PDATA_W-rrgs_pkg::CYC_W){1'b0}}, cycle_ms_reg};
            default:
                prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // handshake: take a new item whenever the result slot frees up
    // ---------------------------------------------------------------
    assign din.ready = !out_valid_reg || dout.ready;
    assign in_fire   = din.valid && din.ready;

    // a fast object (|rel speed| >= 36 km/h) is treated as no object
    assign rel_fast = (din.obj_rel_speed >= rrgs_pkg::V_REL_MAX) ||
                      (din.obj_rel_speed <= -rrgs_pkg::V_REL_MAX);
    assign obj_eff  = din.obj_present && !rel_fast;

    // ---------------------------------------------------------------
    // resolution rules: object mode is three-state, speed-only two-state
    // ---------------------------------------------------------------
    always_comb
    begin
        rule_state = gate_state_reg;
        rule_code  = rrgs_pkg::CODE_LOW;
        if (object_mode_reg)
        begin
            case (gate_state_reg)
                rrgs_pkg::GATE_LOW:
                begin
                    rule_code = rrgs_pkg::CODE_LOW;
                    if (din.ego_speed < rrgs_pkg::V_CREEP_DOWN)
                    begin
                        rule_state = rrgs_pkg::GATE_HIGH;
                    end
                    else if (obj_eff)
                    begin
                        // near object: closer cut-in distance at higher speed
                        if (din.ego_speed >= rrgs_pkg::V_GATE_DOWN)
                        begin
                            if (din.obj_distance < rrgs_pkg::D_NEAR_HIGH_IN)
                            begin
                                rule_state = rrgs_pkg::GATE_INTER;
                            end
                        end
                        else if (din.obj_distance < rrgs_pkg::D_NEAR_LOW_IN)
                        begin
                            rule_state = rrgs_pkg::GATE_INTER;
                        end
                    end
                end
                rrgs_pkg::GATE_HIGH:
                begin
                    rule_code = rrgs_pkg::CODE_HIGH;
                    if (!obj_eff)
                    begin
                        if (din.ego_speed > rrgs_pkg::V_CREEP_UP)
                        begin
                            rule_state = rrgs_pkg::GATE_LOW;
                        end
                    end
                    else if ((din.ego_speed > rrgs_pkg::V_FOLLOW) &&
                             (((din.ego_speed >= rrgs_pkg::V_GATE_UP) &&
                               (din.obj_distance > rrgs_pkg::D_TAIL_HIGH_OUT)) ||
                              ((din.ego_speed < rrgs_pkg::V_GATE_UP) &&
                               (din.obj_distance > rrgs_pkg::D_TAIL_LOW_OUT))))
                    begin
                        rule_state = rrgs_pkg::GATE_INTER;
                    end
                end
                rrgs_pkg::GATE_INTER:
                begin
                    rule_code = rrgs_pkg::CODE_INTER;
                    if (din.ego_speed < rrgs_pkg::V_CREEP_DOWN)
                    begin
                        rule_state = rrgs_pkg::GATE_HIGH;
                    end
                    else if (!obj_eff)
                    begin
                        rule_state = rrgs_pkg::GATE_LOW;
                    end
                    else if (((din.ego_speed >= rrgs_pkg::V_GATE_UP) &&
                              (din.obj_distance > rrgs_pkg::D_NEAR_HIGH_OUT)) ||
                             ((din.ego_speed < rrgs_pkg::V_GATE_UP) &&
                              (din.obj_distance > rrgs_pkg::D_NEAR_LOW_OUT)))
                    begin
                        rule_state = rrgs_pkg::GATE_LOW;
                    end
                    else if (((din.ego_speed >= rrgs_pkg::V_GATE_DOWN) &&
                              (din.obj_distance < rrgs_pkg::D_TAIL_HIGH_IN)) ||
                             ((din.ego_speed < rrgs_pkg::V_GATE_DOWN) &&
                              (din.obj_distance < rrgs_pkg::D_TAIL_LOW_IN)))
                    begin
                        rule_state = rrgs_pkg::GATE_HIGH;
                    end
                end
                default:
                begin
                    rule_state = rrgs_pkg::GATE_LOW;
                    rule_code  = rrgs_pkg::CODE_LOW;
                end
            endcase
        end
        else
        begin
            // speed-only: a non-low state reports 0.5 m unless the speed is above 15 km/h
            if (gate_state_reg != rrgs_pkg::GATE_LOW)
            begin
                if (din.ego_speed > rrgs_pkg::V_SO_COARSE)
                begin
                    rule_state = rrgs_pkg::GATE_LOW;
                    rule_code  = rrgs_pkg::CODE_LOW;
                end
                else
                begin
                    rule_code  = rrgs_pkg::CODE_INTER;
                end
            end
            else if (din.ego_speed < rrgs_pkg::V_SO_FINE)
            begin
                rule_state = rrgs_pkg::GATE_HIGH;
                rule_code  = rrgs_pkg::CODE_INTER;
            end
            else
            begin
                rule_code  = rrgs_pkg::CODE_LOW;
            end
        end
    end

    // invalid speed gives 1 m and freezes the state; overrides force 0.25 m
    always_comb
    begin
        gate_state_next = gate_state_reg;
        gate_code_next  = rrgs_pkg::CODE_LOW;
        if (din.speed_valid)
        begin
            gate_state_next = rule_state;
            gate_code_next  = rule_code;
        end
        if (din.roadbeam_request || din.forced_high_res)
        begin
            gate_code_next = rrgs_pkg::CODE_HIGH;
        end
    end

    // ---------------------------------------------------------------
    // standstill delay counter, saturating at full scale
    // ---------------------------------------------------------------
    assign pr_wanted = din.standstill && !(use_ctrl_status_reg && din.ctrl_enabled);
    assign ms_sum    = {1'b0, standstill_ms_reg} +
                       {{(rrgs_pkg::MS_W+1-rrgs_pkg::CYC_W){1'b0}}, cycle_ms_reg};

    always_comb
    begin
        standstill_ms_next   = standstill_ms_reg;
        power_reduction_next = 1'b0;
        if (!pr_wanted)
        begin
            standstill_ms_next = '0;
        end
        else if (standstill_ms_reg < delay_ms_reg)
        begin
            standstill_ms_next = ms_sum[rrgs_pkg::MS_W] ? '1 : ms_sum[rrgs_pkg::MS_W-1:0];
        end
        else
        begin
            power_reduction_next = 1'b1;
        end
    end

    // ---------------------------------------------------------------
    // state and output register
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gate_state_reg    <= rrgs_pkg::GATE_LOW;
            standstill_ms_reg <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                gate_state_reg    <= gate_state_next;
                standstill_ms_reg <= standstill_ms_next;
                out_valid_reg     <= 1'b1;
            end
            else if (dout.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload needs no reset
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            gate_code_reg       <= gate_code_next;
            power_reduction_reg <= power_reduction_next;
        end
    end

    assign dout.valid           = out_valid_reg;
    assign dout.gate_code       = gate_code_reg;
    assign dout.power_reduction = power_reduction_reg;

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------
    a_override_high: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && (din.roadbeam_request || din.forced_high_res)
        |=> dout.gate_code == rrgs_pkg::CODE_HIGH)
        else $error("override item did not give the fine gate");

    a_invalid_speed_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && !din.speed_valid |=> $stable(gate_state_reg))
        else $error("gate state moved on an item with invalid speed");

    a_counter_clear: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && !din.standstill |=> standstill_ms_reg == '0 && !dout.power_reduction)
        else $error("standstill counter not cleared when moving");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> din.ready)
        else $error("input stalled while the output register is empty");

    a_result_follows_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> out_valid_reg)
        else $error("accepted item produced no result");

endmodule

`default_nettype wire
